### sv/rgb_hsv_pkg.sv
package rgb_hsv_pkg;

   localparam int CH_W   = 8;
   localparam int HUE_W  = 9;
   localparam int PCT_W  = 7;

   // hue divider: numerator up to 300*255, quotient up to 300
   localparam int HUE_NW = 17;
   localparam int HUE_QW = 9;
   // saturation divider: numerator up to 100*255, quotient up to 100
   localparam int SAT_NW = 15;
   localparam int SAT_QW = 7;

   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = (HUE_QW + DIV_STEPS - 1) / DIV_STEPS;

   localparam logic [PCT_W-1:0]  PCT_SCALE  = 7'd100;
   localparam logic [5:0]        DEG_SECTOR = 6'd60;
   localparam logic [HUE_W-1:0]  DEG_TURN   = 9'd360;
   localparam logic [CH_W-1:0]   OFF_GREEN  = 8'd120;
   localparam logic [CH_W-1:0]   OFF_BLUE   = 8'd240;
   localparam logic [CH_W-1:0]   DARK_MAX   = 8'd2;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      chan_type        hi;
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] delta;
   } front_type;

   typedef struct packed {
      logic [HUE_NW-1:0] hue_rem;
      logic [HUE_QW-1:0] hue_quo;
      logic [CH_W-1:0]   delta;
      logic              hue_neg;
      logic              gray;
      logic [SAT_NW-1:0] sat_rem;
      logic [SAT_QW-1:0] sat_quo;
      logic [CH_W-1:0]   mx;
      logic              dark;
      logic [PCT_W-1:0]  val;
   } div_type;

endpackage

### sv/rgb_hsv_if.sv
interface rgb_hsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb_hsv_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] hue;
   logic [6:0] saturation;
   logic [6:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

### sv/rgb_hsv_front.sv
module rgb_hsv_front (
   input  logic                 clock,
   input  logic                 reset,
   rgb_hsv_req_if.sink          req_ch,
   output logic                 o_valid,
   input  logic                 o_ready,
   output rgb_hsv_pkg::div_type o_data
);
   import rgb_hsv_pkg::*;

   logic      a_valid_ff;
   front_type a_ff;
   front_type a_in;
   logic      a_load;

   logic      b_valid_ff;
   div_type   b_ff;
   div_type   b_in;
   logic      b_load;

   assign b_load = !b_valid_ff || o_ready;
   assign a_load = !a_valid_ff || b_load;
   assign req_ch.ready = a_load;

   // stage a: largest and smallest channel, ties to the lower index
   always_comb begin
      logic [CH_W-1:0] mn;
      a_in.red   = req_ch.red;
      a_in.green = req_ch.green;
      a_in.blue  = req_ch.blue;
      a_in.hi    = CH_RED;
      a_in.mx    = req_ch.red;
      mn         = req_ch.red;
      if (req_ch.green > a_in.mx) begin
         a_in.hi = CH_GREEN;
         a_in.mx = req_ch.green;
      end
      if (req_ch.blue > a_in.mx) begin
         a_in.hi = CH_BLUE;
         a_in.mx = req_ch.blue;
      end
      if (req_ch.green < mn) begin
         mn = req_ch.green;
      end
      if (req_ch.blue < mn) begin
         mn = req_ch.blue;
      end
      a_in.delta = a_in.mx - mn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load && req_ch.valid) begin
         a_ff <= a_in;
      end
   end

   // stage b: dividends for hue and saturation, value by reciprocal of 255
   always_comb begin
      logic signed [CH_W:0]     diff;
      logic signed [HUE_NW:0]   diff_w;
      logic signed [HUE_NW:0]   sum_w;
      logic [CH_W-1:0]          mag;
      logic [HUE_NW-1:0]        off_term;
      logic [SAT_NW-1:0]        scaled;
      logic [SAT_NW:0]          recip;
      diff     = '0;
      off_term = '0;
      unique case (a_ff.hi)
         CH_RED: begin
            diff = $signed({1'b0, a_ff.green}) - $signed({1'b0, a_ff.blue});
         end
         CH_GREEN: begin
            diff     = $signed({1'b0, a_ff.blue}) - $signed({1'b0, a_ff.red});
            off_term = HUE_NW'(a_ff.delta) * HUE_NW'(OFF_GREEN);
         end
         CH_BLUE: begin
            diff     = $signed({1'b0, a_ff.red}) - $signed({1'b0, a_ff.green});
            off_term = HUE_NW'(a_ff.delta) * HUE_NW'(OFF_BLUE);
         end
         default: begin
            diff = '0;
         end
      endcase
      diff_w = {{(HUE_NW - CH_W){diff[CH_W]}}, diff};
      mag    = diff[CH_W] ? CH_W'(-diff) : CH_W'(diff);
      sum_w  = diff_w * $signed({1'b0, HUE_NW'(DEG_SECTOR)})
               + $signed({1'b0, off_term});

      b_in.hue_quo = '0;
      b_in.delta   = a_ff.delta;
      b_in.gray    = (a_ff.delta == '0);
      if (a_ff.hi == CH_RED) begin
         b_in.hue_rem = HUE_NW'(mag) * HUE_NW'(DEG_SECTOR);
         b_in.hue_neg = diff[CH_W];
      end else begin
         b_in.hue_rem = sum_w[HUE_NW-1:0];
         b_in.hue_neg = 1'b0;
      end

      b_in.sat_rem = SAT_NW'(a_ff.delta) * SAT_NW'(PCT_SCALE);
      b_in.sat_quo = '0;
      b_in.mx      = a_ff.mx;
      b_in.dark    = (a_ff.mx <= DARK_MAX);

      scaled   = SAT_NW'(a_ff.mx) * SAT_NW'(PCT_SCALE);
      recip    = (SAT_NW + 1)'(scaled) + (SAT_NW + 1)'(scaled >> CH_W) + (SAT_NW + 1)'(1);
      b_in.val = PCT_W'(recip >> CH_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_load) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

   assign o_valid = b_valid_ff;
   assign o_data  = b_ff;

endmodule

### sv/rgb_hsv_div_stage.sv
module rgb_hsv_div_stage #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 i_valid,
   output logic                 i_ready,
   input  rgb_hsv_pkg::div_type i_data,
   output logic                 o_valid,
   input  logic                 o_ready,
   output rgb_hsv_pkg::div_type o_data
);
   import rgb_hsv_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic    load;

   assign load    = !valid_ff || o_ready;
   assign i_ready = load;

   // restoring division, a few quotient bits per stage for both dividers
   always_comb begin
      int                hk;
      int                sk;
      logic [HUE_NW-1:0] hsh;
      logic [SAT_NW-1:0] ssh;
      data_in = i_data;
      hsh     = '0;
      ssh     = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
         hk = HUE_QW - 1 - DIV_STEPS * STAGE - j;
         sk = SAT_QW - 1 - DIV_STEPS * STAGE - j;
         if (hk >= 0) begin
            hsh = HUE_NW'(data_in.delta) << hk;
            if (data_in.hue_rem >= hsh) begin
               data_in.hue_rem = data_in.hue_rem - hsh;
               data_in.hue_quo = data_in.hue_quo | (HUE_QW'(1) << hk);
            end
         end
         if (sk >= 0) begin
            ssh = SAT_NW'(data_in.mx) << sk;
            if (data_in.sat_rem >= ssh) begin
               data_in.sat_rem = data_in.sat_rem - ssh;
               data_in.sat_quo = data_in.sat_quo | (SAT_QW'(1) << sk);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= i_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && i_valid) begin
         data_ff <= data_in;
      end
   end

   assign o_valid = valid_ff;
   assign o_data  = data_ff;

endmodule

### sv/rgb_hsv_finish.sv
module rgb_hsv_finish (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 i_valid,
   output logic                 i_ready,
   input  rgb_hsv_pkg::div_type i_data,
   rgb_hsv_rsp_if.source        rsp_ch
);
   import rgb_hsv_pkg::*;

   logic             valid_ff;
   logic [HUE_W-1:0] hue_ff;
   logic [HUE_W-1:0] hue_in;
   logic [PCT_W-1:0] sat_ff;
   logic [PCT_W-1:0] sat_in;
   logic [PCT_W-1:0] val_ff;
   logic             load;

   assign load    = !valid_ff || rsp_ch.ready;
   assign i_ready = load;

   // negative red-sector hue wraps by a full turn, truncation to zero stays zero
   always_comb begin
      if (i_data.gray) begin
         hue_in = '0;
      end else if (i_data.hue_neg && (i_data.hue_quo != '0)) begin
         hue_in = DEG_TURN - i_data.hue_quo;
      end else if (i_data.hue_neg) begin
         hue_in = '0;
      end else begin
         hue_in = i_data.hue_quo;
      end
      sat_in = i_data.dark ? '0 : i_data.sat_quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= i_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && i_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= i_data.val;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.hue        = hue_ff;
   assign rsp_ch.saturation = sat_ff;
   assign rsp_ch.brightness = val_ff;

endmodule

### sv/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter, 8-bit channels in, whole-number HSV out.
// req_ch carries one pixel per beat (red, green, blue); rsp_ch returns one
// beat per pixel with hue in degrees 0..359, saturation and brightness in
// percent 0..100, in the order the pixels came in.
// Both channels use valid/ready; a beat moves when both are high.
// An accepted pixel passes six registered stages on its way to rsp_ch:
// two front stages (max/min, then dividends and brightness), three divider
// stages that each resolve up to three quotient bits of the hue and saturation
// restoring dividers, and the output register.
// Throughput is one pixel per clock while rsp_ch.ready stays high; the divider stages set the depth.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls.
// While rsp_ch.ready is low the held result stays put and req_ch keeps
// accepting until all six stages are full; no beat is dropped or repeated.
// Synchronous reset empties all stages; the block has no other state.
module rgb_to_hsv_converter (
   input  logic           clock,
   input  logic           reset,
   rgb_hsv_req_if.sink    req_ch,
   rgb_hsv_rsp_if.source  rsp_ch
);
   import rgb_hsv_pkg::*;

   logic    stg_valid [DIV_STAGES+1];
   logic    stg_ready [DIV_STAGES+1];
   div_type stg_data  [DIV_STAGES+1];

   rgb_hsv_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .o_valid (stg_valid[0]),
      .o_ready (stg_ready[0]),
      .o_data  (stg_data[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rgb_hsv_div_stage #(
         .STAGE (s)
      ) u_div (
         .clock   (clock),
         .reset   (reset),
         .i_valid (stg_valid[s]),
         .i_ready (stg_ready[s]),
         .i_data  (stg_data[s]),
         .o_valid (stg_valid[s+1]),
         .o_ready (stg_ready[s+1]),
         .o_data  (stg_data[s+1])
      );
   end

   rgb_hsv_finish u_finish (
      .clock   (clock),
      .reset   (reset),
      .i_valid (stg_valid[DIV_STAGES]),
      .i_ready (stg_ready[DIV_STAGES]),
      .i_data  (stg_data[DIV_STAGES]),
      .rsp_ch  (rsp_ch)
   );

endmodule
